[src/lzwd_pkg.sv]
// Package for the LZW stream decoder: stream states, response codes,
// controller states, datapath operations and the control/status structs.
// Depends on nothing.
`default_nettype none

package lzwd_pkg;

   localparam int CLEAR_CODE = 256;
   localparam int FIRST_FREE = 257;
   localparam int FIRST_WIDTH = 9;
   localparam int LITERALS = 256;

   typedef enum logic [1:0] {
      ST_RUNNING  = 2'd0,
      ST_DRAINING = 2'd1,
      ST_ENDED    = 2'd2,
      ST_ERROR    = 2'd3
   } stream_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_BUSY  = 2'd1,
      STAT_ENDED = 2'd2,
      STAT_ERROR = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_POP_WAIT,
      S_LOOP,
      S_WALK_RD,
      S_WALK_USE,
      S_FEED_END
   } ctl_state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START,
      OP_FIN,
      OP_PULL_EMPTY,
      OP_POP_RD,
      OP_POP_OUT,
      OP_APPEND,
      OP_SKIP,
      OP_CODE,
      OP_DICT_RD,
      OP_WALK_PUSH,
      OP_CODE_END,
      OP_FEED_END
   } op_type;

   typedef struct packed {
      op_type     op;
      logic       fin;
      status_type status;
   } cmd_type;

   typedef struct packed {
      stream_type st;
      logic       kind;
      logic       stack_empty;
      logic       skip_nz;
      logic       skip_fits;
      logic       can_decode;
      logic       code_clear;
      logic       code_bad;
      logic       walk_more;
   } stat_type;

endpackage

`default_nettype wire

[src/lzwd_ctl.sv]
// Sequencer of the LZW decoder: walks one item through dispatch, pull,
// code unpacking and the dictionary chain. Uses lzwd_pkg.
`default_nettype none

module lzwd_ctl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lzwd_pkg::stat_type stat,
   output lzwd_pkg::cmd_type      cmd,
   output logic                   idle
);

   lzwd_pkg::ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzwd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lzwd_pkg::S_IDLE: begin
            if (start) state_in = lzwd_pkg::S_DISPATCH;
         end
         lzwd_pkg::S_DISPATCH: begin
            state_in = lzwd_pkg::S_IDLE;
            if (stat.st != lzwd_pkg::ST_ERROR && stat.st != lzwd_pkg::ST_ENDED) begin
               if (stat.kind) begin
                  if (!stat.stack_empty) state_in = lzwd_pkg::S_POP_WAIT;
               end else if (stat.st != lzwd_pkg::ST_DRAINING && stat.stack_empty) begin
                  state_in = lzwd_pkg::S_LOOP;
               end
            end
         end
         lzwd_pkg::S_POP_WAIT: state_in = lzwd_pkg::S_IDLE;
         lzwd_pkg::S_LOOP: begin
            priority if (stat.skip_nz) begin
               if (!stat.skip_fits) state_in = lzwd_pkg::S_FEED_END;
            end else if (!stat.stack_empty || stat.st == lzwd_pkg::ST_ERROR ||
                         !stat.can_decode) begin
               state_in = lzwd_pkg::S_IDLE;
            end else if (!stat.code_clear && !stat.code_bad) begin
               state_in = lzwd_pkg::S_WALK_RD;
            end
         end
         lzwd_pkg::S_WALK_RD: begin
            state_in = stat.walk_more ? lzwd_pkg::S_WALK_USE : lzwd_pkg::S_LOOP;
         end
         lzwd_pkg::S_WALK_USE: state_in = lzwd_pkg::S_WALK_RD;
         lzwd_pkg::S_FEED_END: state_in = lzwd_pkg::S_IDLE;
         default: state_in = lzwd_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = lzwd_pkg::OP_NONE;
      cmd.fin = 1'b0;
      cmd.status = lzwd_pkg::STAT_OK;
      idle = (state_ff == lzwd_pkg::S_IDLE);
      unique case (state_ff)
         lzwd_pkg::S_IDLE: begin
            if (start) cmd.op = lzwd_pkg::OP_START;
         end
         lzwd_pkg::S_DISPATCH: begin
            priority if (stat.st == lzwd_pkg::ST_ERROR) begin
               cmd.op = lzwd_pkg::OP_FIN;
               cmd.fin = 1'b1;
               cmd.status = lzwd_pkg::STAT_ERROR;
            end else if (stat.st == lzwd_pkg::ST_ENDED) begin
               cmd.op = lzwd_pkg::OP_FIN;
               cmd.fin = 1'b1;
               cmd.status = lzwd_pkg::STAT_ENDED;
            end else if (stat.kind) begin
               if (stat.stack_empty) begin
                  cmd.op = lzwd_pkg::OP_PULL_EMPTY;
                  cmd.fin = 1'b1;
               end else begin
                  cmd.op = lzwd_pkg::OP_POP_RD;
               end
            end else if (stat.st == lzwd_pkg::ST_DRAINING) begin
               cmd.op = lzwd_pkg::OP_FIN;
               cmd.fin = 1'b1;
               cmd.status = lzwd_pkg::STAT_ENDED;
            end else if (!stat.stack_empty) begin
               cmd.op = lzwd_pkg::OP_FIN;
               cmd.fin = 1'b1;
               cmd.status = lzwd_pkg::STAT_BUSY;
            end else begin
               cmd.op = lzwd_pkg::OP_APPEND;
            end
         end
         lzwd_pkg::S_POP_WAIT: begin
            cmd.op = lzwd_pkg::OP_POP_OUT;
            cmd.fin = 1'b1;
         end
         lzwd_pkg::S_LOOP: begin
            priority if (stat.skip_nz) begin
               cmd.op = lzwd_pkg::OP_SKIP;
            end else if (!stat.stack_empty || stat.st == lzwd_pkg::ST_ERROR ||
                         !stat.can_decode) begin
               cmd.op = lzwd_pkg::OP_FEED_END;
               cmd.fin = 1'b1;
            end else begin
               cmd.op = lzwd_pkg::OP_CODE;
            end
         end
         lzwd_pkg::S_WALK_RD: begin
            cmd.op = stat.walk_more ? lzwd_pkg::OP_DICT_RD : lzwd_pkg::OP_CODE_END;
         end
         lzwd_pkg::S_WALK_USE: cmd.op = lzwd_pkg::OP_WALK_PUSH;
         lzwd_pkg::S_FEED_END: begin
            cmd.op = lzwd_pkg::OP_FEED_END;
            cmd.fin = 1'b1;
         end
         default: cmd.op = lzwd_pkg::OP_NONE;
      endcase
   end

endmodule

`default_nettype wire

[src/lzwd_dp.sv]
// Datapath of the LZW decoder: bit buffer, code state, dictionary and
// string stack memories, response registers. Uses lzwd_pkg.
`default_nettype none

module lzwd_dp #(
   parameter int MAX_CODE_BITS = 14
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lzwd_pkg::cmd_type  cmd,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               req_in_last,
   input  wire logic [31:0]        limit,
   output lzwd_pkg::stat_type      stat,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_out_valid,
   output logic [1:0]              rsp_status,
   output logic [31:0]             rsp_bytes_out
);

   localparam int W = MAX_CODE_BITS;
   localparam int DEPTH = 1 << W;
   localparam int CWB = $clog2(W + 1);

   logic [7:0]   stack_mem [DEPTH];
   logic [W+7:0] dict_mem  [DEPTH];

   logic [23:0]  buf_ff, buf_in;
   logic [4:0]   cnt_ff, cnt_in;
   logic [CWB-1:0] cw_ff, cw_in;
   logic [W:0]   nfc_ff, nfc_in;
   logic [W-1:0] prev_ff, prev_in;
   logic         pv_ff, pv_in;
   logic [7:0]   fc_ff, fc_in;
   logic [2:0]   grp_ff, grp_in;
   logic [6:0]   skip_ff, skip_in;
   logic [31:0]  emit_ff, emit_in;
   lzwd_pkg::stream_type st_ff, st_in, st_eff;
   logic [W:0]   sc_ff, sc_in;
   logic [W:0]   sp_ff, sp_in;
   logic [W-1:0] c_ff, c_in;
   logic [W-1:0] code_ff, code_in;
   logic         kind_ff, last_ff;
   logic [7:0]   byte_ff;
   logic [7:0]   stack_q;
   logic [W+7:0] dict_q;
   logic [7:0]   rbyte_ff, rbyte_in;
   logic         rvalid_ff, rvalid_in;
   lzwd_pkg::status_type rstat_ff, rstat_in;

   logic [W-1:0] code, mask;
   logic [2:0]   grp_inc;
   logic [4:0]   take;
   logic [W:0]   nfc_inc;
   logic [W+1:0] width_lim;
   logic         stk_we, dict_we;
   logic [W-1:0] stk_addr;
   logic [7:0]   stk_data;
   logic [31:0]  shifted;

   assign mask = (W'(1) << cw_ff) - W'(1);
   assign code = buf_ff[W-1:0] & mask;
   assign grp_inc = grp_ff + 3'd1;
   assign take = ({2'b0, skip_ff} < {4'b0, cnt_ff}) ? skip_ff[4:0] : cnt_ff;
   assign nfc_inc = nfc_ff + (W+1)'(1);
   assign width_lim = (W+2)'(1) << cw_ff;
   assign shifted = {24'b0, byte_ff} << cnt_ff;

   assign st_eff = ((st_ff == lzwd_pkg::ST_RUNNING || st_ff == lzwd_pkg::ST_DRAINING) &&
                    emit_ff >= limit) ? lzwd_pkg::ST_ENDED : st_ff;

   assign stat.st = st_ff;
   assign stat.kind = kind_ff;
   assign stat.stack_empty = (sc_ff == '0);
   assign stat.skip_nz = (skip_ff != '0);
   assign stat.skip_fits = ({2'b0, skip_ff} <= {4'b0, cnt_ff});
   assign stat.can_decode = (cnt_ff >= 5'(cw_ff));
   assign stat.code_clear = (code == W'(lzwd_pkg::CLEAR_CODE));
   assign stat.code_bad = ({1'b0, code} > nfc_ff) || ({1'b0, code} == nfc_ff && !pv_ff);
   assign stat.walk_more = (c_ff >= W'(lzwd_pkg::LITERALS)) && (sp_ff < (W+1)'(DEPTH - 1));

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      cw_in = cw_ff;
      nfc_in = nfc_ff;
      prev_in = prev_ff;
      pv_in = pv_ff;
      fc_in = fc_ff;
      grp_in = grp_ff;
      skip_in = skip_ff;
      emit_in = emit_ff;
      st_in = st_ff;
      sc_in = sc_ff;
      sp_in = sp_ff;
      c_in = c_ff;
      code_in = code_ff;
      rbyte_in = rbyte_ff;
      rvalid_in = rvalid_ff;
      rstat_in = rstat_ff;
      stk_we = 1'b0;
      stk_addr = sp_ff[W-1:0];
      stk_data = c_ff[7:0];
      dict_we = 1'b0;
      if (cmd.fin) begin
         rbyte_in = 8'd0;
         rvalid_in = 1'b0;
         rstat_in = cmd.status;
      end
      unique case (cmd.op)
         lzwd_pkg::OP_START: st_in = st_eff;
         lzwd_pkg::OP_PULL_EMPTY: begin
            if (st_ff == lzwd_pkg::ST_DRAINING) begin
               st_in = lzwd_pkg::ST_ENDED;
               rstat_in = lzwd_pkg::STAT_ENDED;
            end
         end
         lzwd_pkg::OP_POP_RD: sc_in = sc_ff - (W+1)'(1);
         lzwd_pkg::OP_POP_OUT: begin
            rbyte_in = stack_q;
            rvalid_in = 1'b1;
            emit_in = emit_ff + 32'd1;
            if (sc_ff == '0 && st_ff == lzwd_pkg::ST_DRAINING) st_in = lzwd_pkg::ST_ENDED;
         end
         lzwd_pkg::OP_APPEND: begin
            buf_in = buf_ff | shifted[23:0];
            cnt_in = cnt_ff + 5'd8;
         end
         lzwd_pkg::OP_SKIP: begin
            buf_in = buf_ff >> take;
            cnt_in = cnt_ff - take;
            skip_in = skip_ff - {2'b0, take};
         end
         lzwd_pkg::OP_CODE: begin
            buf_in = buf_ff >> cw_ff;
            cnt_in = cnt_ff - 5'(cw_ff);
            grp_in = grp_inc;
            code_in = code;
            priority if (stat.code_clear) begin
               if (grp_inc != 3'd0) skip_in = 7'(cw_ff) * (7'd8 - 7'(grp_inc));
               nfc_in = (W+1)'(lzwd_pkg::FIRST_FREE);
               cw_in = CWB'(lzwd_pkg::FIRST_WIDTH);
               grp_in = 3'd0;
               pv_in = 1'b0;
            end else if (stat.code_bad) begin
               st_in = lzwd_pkg::ST_ERROR;
            end else if ({1'b0, code} == nfc_ff) begin
               stk_we = 1'b1;
               stk_addr = '0;
               stk_data = fc_ff;
               sp_in = (W+1)'(1);
               c_in = prev_ff;
            end else begin
               sp_in = '0;
               c_in = code;
            end
         end
         lzwd_pkg::OP_WALK_PUSH: begin
            stk_we = 1'b1;
            stk_data = dict_q[7:0];
            sp_in = sp_ff + (W+1)'(1);
            c_in = dict_q[W+7:8];
         end
         lzwd_pkg::OP_CODE_END: begin
            stk_we = 1'b1;
            fc_in = c_ff[7:0];
            sc_in = sp_ff + (W+1)'(1);
            if (pv_ff && nfc_ff < (W+1)'(DEPTH)) begin
               dict_we = 1'b1;
               nfc_in = nfc_inc;
               if ({1'b0, nfc_inc} >= width_lim && cw_ff < CWB'(W)) cw_in = cw_ff + CWB'(1);
            end
            prev_in = code_ff;
            pv_in = 1'b1;
         end
         lzwd_pkg::OP_FEED_END: begin
            if (st_ff == lzwd_pkg::ST_ERROR) begin
               rstat_in = lzwd_pkg::STAT_ERROR;
            end else if (last_ff) begin
               buf_in = '0;
               cnt_in = '0;
               skip_in = '0;
               st_in = (sc_ff != '0) ? lzwd_pkg::ST_DRAINING : lzwd_pkg::ST_ENDED;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff <= '0;
         cnt_ff <= '0;
         cw_ff <= CWB'(lzwd_pkg::FIRST_WIDTH);
         nfc_ff <= (W+1)'(lzwd_pkg::FIRST_FREE);
         pv_ff <= 1'b0;
         fc_ff <= '0;
         grp_ff <= '0;
         skip_ff <= '0;
         emit_ff <= '0;
         st_ff <= lzwd_pkg::ST_RUNNING;
         sc_ff <= '0;
      end else begin
         buf_ff <= buf_in;
         cnt_ff <= cnt_in;
         cw_ff <= cw_in;
         nfc_ff <= nfc_in;
         pv_ff <= pv_in;
         fc_ff <= fc_in;
         grp_ff <= grp_in;
         skip_ff <= skip_in;
         emit_ff <= emit_in;
         st_ff <= st_in;
         sc_ff <= sc_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      sp_ff <= sp_in;
      c_ff <= c_in;
      code_ff <= code_in;
      rbyte_ff <= rbyte_in;
      rvalid_ff <= rvalid_in;
      rstat_ff <= rstat_in;
      if (cmd.op == lzwd_pkg::OP_START) begin
         kind_ff <= req_kind;
         byte_ff <= req_in_byte;
         last_ff <= req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_addr] <= stk_data;
      if (cmd.op == lzwd_pkg::OP_POP_RD) stack_q <= stack_mem[sc_in[W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dict_we) dict_mem[nfc_ff[W-1:0]] <= {prev_ff, c_ff[7:0]};
      if (cmd.op == lzwd_pkg::OP_DICT_RD) dict_q <= dict_mem[c_ff];
   end

   assign rsp_out_byte = rbyte_ff;
   assign rsp_out_valid = rvalid_ff;
   assign rsp_status = rstat_ff;
   assign rsp_bytes_out = emit_ff;

endmodule

`default_nettype wire

[src/lzw_compress_decoder_core.sv]
// Top level of the LZW stream decoder: handshakes, limit register,
// response valid. Instantiates lzwd_ctl and lzwd_dp; uses lzwd_pkg.
//
//  channel | ports                                      | direction
//  req     | req_valid req_stall req_kind/in_byte/in_last | in
//  rsp     | rsp_valid rsp_stall rsp_out_byte/out_valid/status/bytes_out | out
//  csr     | csr_valid csr_ready csr_data               | in
//
// A feed works through its skip steps, clear and bad codes, decoded codes and
// the dictionary chain links of each code in turn (one dictionary read port).
// One item is in work at a time; the response register holds a result while
// rsp_stall is high.
// Reset is synchronous; no clearing pass.
`default_nettype none

module lzw_compress_decoder_core #(
   parameter int MAX_CODE_BITS = 14
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_kind,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_bytes_out,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data
);

   lzwd_pkg::cmd_type  cmd;
   lzwd_pkg::stat_type stat;
   logic        idle, start;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] limit_ff, limit_in;

   assign req_stall = !idle || (rsp_valid_ff && rsp_stall);
   assign start = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.fin) rsp_valid_in = 1'b1;
      limit_in = (csr_valid && csr_ready) ? csr_data : limit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         limit_ff <= 32'hFFFF_FFFF;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         limit_ff <= limit_in;
      end
   end

   lzwd_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .idle  (idle)
   );

   lzwd_dp #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_kind      (req_kind),
      .req_in_byte   (req_in_byte),
      .req_in_last   (req_in_last),
      .limit         (limit_ff),
      .stat          (stat),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_status    (rsp_status),
      .rsp_bytes_out (rsp_bytes_out)
   );

endmodule

`default_nettype wire

[src/lzwd_checker.sv]
// Port-level checks for the LZW stream decoder and their bind to the top.
// Uses lzwd_pkg status codes.
`default_nettype none

module lzwd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_out_byte,
   input wire logic        rsp_out_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_bytes_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte) &&
      $stable(rsp_status) && $stable(rsp_bytes_out))
      else $error("stalled item changed");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item accepted while previous one in work");

   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_status == lzwd_pkg::STAT_OK &&
      rsp_bytes_out != 32'd0)
      else $error("decoded byte with bad status or count");

   a_no_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_byte == 8'd0)
      else $error("nonzero byte without valid");

endmodule

bind lzw_compress_decoder_core lzwd_checker u_chk (.*);

`default_nettype wire

[dv/tb_lzw_compress_decoder_core.sv]
// Testbench for lzw_compress_decoder_core: builds LSB-first LZW code streams,
// predicts each response with an in-bench decoder and checks it field by field.
// Depends on lzwd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_lzw_compress_decoder_core;

   localparam int MAX_BITS = 14;
   localparam int DICT_SIZE = 1 << MAX_BITS;
   localparam int WATCHDOG = 20000;
   localparam int CHUNK = 60;

   typedef struct packed {
      bit       kind;
      bit [7:0] byt;
      bit       last;
   } req_item_type;

   typedef struct packed {
      bit [7:0]             obyte;
      bit                   ovalid;
      lzwd_pkg::status_type st;
      bit [31:0]            nout;
   } rsp_item_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic        req_kind = 0;
   logic [7:0]  req_in_byte = 0;
   logic        req_in_last = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_out_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_bytes_out;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [31:0] csr_data = 0;

   lzw_compress_decoder_core #(.MAX_CODE_BITS(MAX_BITS)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_in_byte(req_in_byte), .req_in_last(req_in_last),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_out_byte(rsp_out_byte),
      .rsp_out_valid(rsp_out_valid), .rsp_status(rsp_status),
      .rsp_bytes_out(rsp_bytes_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   req_item_type pending_reqs[$];
   rsp_item_type expected_rsps[$];
   int unsigned mode = 0;
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;
   int unsigned pushed = 0;

   // decoder state
   bit [13:0]   dict_pre[DICT_SIZE];
   bit [7:0]    dict_chr[DICT_SIZE];
   bit [7:0]    str_stack[DICT_SIZE];
   int unsigned stk_n = 0, bbuf = 0, bcnt = 0;
   int unsigned cw = lzwd_pkg::FIRST_WIDTH, nfc = lzwd_pkg::FIRST_FREE;
   int unsigned prev = 0, grp = 0, skip = 0;
   bit          prev_ok = 0;
   bit [7:0]    fchar = 0;
   bit [31:0]   emitted = 0;
   bit [31:0]   limit_reg = 32'hFFFF_FFFF;
   lzwd_pkg::stream_type sst = lzwd_pkg::ST_RUNNING;

   // code stream builder state
   bit          bitq[$];
   int unsigned forced_codes[$];
   int unsigned g_cw = lzwd_pkg::FIRST_WIDTH, g_nfc = lzwd_pkg::FIRST_FREE, g_grp = 0;
   bit          g_prev_ok = 0;

   initial forever #5 clock = ~clock;

   function automatic void decode_code(int unsigned code);
      int unsigned sp, c, idx;
      sp = 0;
      c = code;
      grp = (grp + 1) & 7;
      if (code == lzwd_pkg::CLEAR_CODE) begin
         if (grp != 0) skip = cw * (8 - grp);
         nfc = lzwd_pkg::FIRST_FREE;
         cw = lzwd_pkg::FIRST_WIDTH;
         grp = 0;
         prev_ok = 0;
         return;
      end
      if (code > nfc || (code == nfc && !prev_ok)) begin
         sst = lzwd_pkg::ST_ERROR;
         return;
      end
      if (c == nfc) begin
         str_stack[sp] = fchar;
         sp++;
         c = prev;
      end
      while (c >= lzwd_pkg::LITERALS && sp < DICT_SIZE - 1) begin
         idx = c & (DICT_SIZE - 1);
         str_stack[sp] = dict_chr[idx];
         sp++;
         c = dict_pre[idx];
      end
      str_stack[sp] = c[7:0];
      sp++;
      fchar = c[7:0];
      stk_n = sp;
      if (prev_ok && nfc < DICT_SIZE) begin
         dict_pre[nfc] = prev[13:0];
         dict_chr[nfc] = fchar;
         nfc++;
         if (nfc >= (1 << cw) && cw < MAX_BITS) cw++;
      end
      prev = code;
      prev_ok = 1;
   endfunction

   function automatic rsp_item_type decode_step(req_item_type it);
      rsp_item_type r;
      int unsigned take, code;
      r = '0;
      r.st = lzwd_pkg::STAT_OK;
      if ((sst == lzwd_pkg::ST_RUNNING || sst == lzwd_pkg::ST_DRAINING) &&
          emitted >= limit_reg)
         sst = lzwd_pkg::ST_ENDED;
      if (sst == lzwd_pkg::ST_ERROR) begin
         r.st = lzwd_pkg::STAT_ERROR;
      end else if (sst == lzwd_pkg::ST_ENDED) begin
         r.st = lzwd_pkg::STAT_ENDED;
      end else if (it.kind) begin
         if (stk_n > 0) begin
            stk_n--;
            r.obyte = str_stack[stk_n];
            r.ovalid = 1;
            emitted++;
            if (stk_n == 0 && sst == lzwd_pkg::ST_DRAINING) sst = lzwd_pkg::ST_ENDED;
         end else if (sst == lzwd_pkg::ST_DRAINING) begin
            sst = lzwd_pkg::ST_ENDED;
            r.st = lzwd_pkg::STAT_ENDED;
         end
      end else if (sst == lzwd_pkg::ST_DRAINING) begin
         r.st = lzwd_pkg::STAT_ENDED;
      end else if (stk_n > 0) begin
         r.st = lzwd_pkg::STAT_BUSY;
      end else begin
         bbuf = (bbuf | (32'(it.byt) << bcnt)) & 32'hFF_FFFF;
         bcnt += 8;
         while (1) begin
            if (skip > 0) begin
               take = (skip < bcnt) ? skip : bcnt;
               bbuf >>= take;
               bcnt -= take;
               skip -= take;
               if (skip > 0) break;
               continue;
            end
            if (stk_n > 0 || sst == lzwd_pkg::ST_ERROR || bcnt < cw) break;
            code = bbuf & ((1 << cw) - 1);
            bbuf >>= cw;
            bcnt -= cw;
            decode_code(code);
         end
         if (sst == lzwd_pkg::ST_ERROR) begin
            r.st = lzwd_pkg::STAT_ERROR;
         end else if (it.last) begin
            bbuf = 0;
            bcnt = 0;
            skip = 0;
            sst = (stk_n > 0) ? lzwd_pkg::ST_DRAINING : lzwd_pkg::ST_ENDED;
         end
      end
      r.nout = emitted;
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic push_item(bit kind, bit [7:0] byt, bit last);
      req_item_type it;
      it = '{kind: kind, byt: byt, last: last};
      expected_rsps.push_back(decode_step(it));
      pending_reqs.push_back(it);
      pushed++;
      if (pushed % CHUNK == 0) begin
         while (pending_reqs.size() != 0) @(posedge clock);
         mode = (mode + 1) % 4;
      end
   endtask

   task automatic write_limit(bit [31:0] value);
      drain();
      repeat (8) @(posedge clock);
      csr_valid <= 1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      limit_reg = value;
   endtask

   function automatic int unsigned pick_code();
      int unsigned r;
      if (forced_codes.size() != 0) return forced_codes.pop_front();
      r = $urandom_range(0, 99);
      if (!g_prev_ok) return $urandom_range(0, 255);
      if (r < 1) return lzwd_pkg::CLEAR_CODE;
      if (r < 5) return g_nfc;
      if (r < 25 && g_nfc > lzwd_pkg::FIRST_FREE)
         return $urandom_range(lzwd_pkg::FIRST_FREE, g_nfc - 1);
      return $urandom_range(0, 255);
   endfunction

   function automatic void emit_code(int unsigned code);
      for (int k = 0; k < g_cw; k++) bitq.push_back(code[k]);
      g_grp = (g_grp + 1) & 7;
      if (code == lzwd_pkg::CLEAR_CODE) begin
         if (g_grp != 0)
            for (int k = 0; k < g_cw * (8 - g_grp); k++) bitq.push_back($urandom_range(0, 1));
         g_nfc = lzwd_pkg::FIRST_FREE;
         g_cw = lzwd_pkg::FIRST_WIDTH;
         g_grp = 0;
         g_prev_ok = 0;
         return;
      end
      if (g_prev_ok && g_nfc < DICT_SIZE) begin
         g_nfc++;
         if (g_nfc >= (1 << g_cw) && g_cw < MAX_BITS) g_cw++;
      end
      g_prev_ok = 1;
   endfunction

   task automatic feed_stream(bit last);
      bit [7:0] b;
      while (bitq.size() < 8) emit_code(pick_code());
      for (int k = 0; k < 8; k++) b[k] = bitq.pop_front();
      push_item(0, b, last);
   endtask

   task automatic next_item();
      if (stk_n > 0) begin
         if ($urandom_range(0, 99) < 8)
            push_item(0, $urandom_range(0, 255), $urandom_range(0, 1));
         else
            push_item(1, $urandom_range(0, 255), $urandom_range(0, 1));
      end else if ($urandom_range(0, 99) < 6) begin
         push_item(1, $urandom_range(0, 255), $urandom_range(0, 1));
      end else begin
         feed_stream(0);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) void'(pending_reqs.pop_front());
         if (pending_reqs.size() != 0 &&
             !((mode == 1 && $urandom_range(0, 99) < 62) ||
               (mode == 3 && $urandom_range(0, 99) < 21))) begin
            req_valid <= 1;
            req_kind <= pending_reqs[0].kind;
            req_in_byte <= pending_reqs[0].byt;
            req_in_last <= pending_reqs[0].last;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin
      rsp_item_type e;
      rsp_stall <= (mode == 2 && $urandom_range(0, 99) < 62) ||
                   (mode == 3 && $urandom_range(0, 99) < 21);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: byte %0h status %0d",
                                           rsp_out_byte, rsp_status);
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_out_byte !== e.obyte || rsp_out_valid !== e.ovalid ||
                rsp_status !== e.st || rsp_bytes_out !== e.nout) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp byte %0h valid %0d status %0d count %0d, ",
                            "got %0h %0d %0d %0d"},
                           e.obyte, e.ovalid, e.st, e.nout,
                           rsp_out_byte, rsp_out_valid, rsp_status, rsp_bytes_out);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int unsigned ending, guard;
      repeat (5) @(posedge clock);
      reset <= 0;
      write_limit(32'hFFFF_FFFF);

      // literal extremes, chain, repeated-string code, clear with padding,
      // dictionary code right after a clear
      forced_codes = '{0, 255, 65, 66, 257, 261, lzwd_pkg::CLEAR_CODE, 65, 65, 257};
      repeat (25) next_item();

      guard = 0;
      while (pushed < 450 && guard < 2500 && sst == lzwd_pkg::ST_RUNNING) begin
         next_item();
         guard++;
      end

      ending = $urandom_range(0, 2);
      if (ending == 0) begin
         guard = 0;
         while (stk_n > 0 && guard < 2000) begin
            push_item(1, $urandom_range(0, 255), 0);
            guard++;
         end
         feed_stream(1);
         guard = 0;
         while (sst != lzwd_pkg::ST_ENDED && sst != lzwd_pkg::ST_ERROR && guard < 2000) begin
            push_item(1, $urandom_range(0, 255), 0);
            guard++;
         end
         push_item(0, $urandom_range(0, 255), 1);
         push_item(1, 0, 0);
      end else if (ending == 1) begin
         if (g_prev_ok && g_nfc + 1 < (1 << g_cw) && $urandom_range(0, 1))
            forced_codes = '{$urandom_range(g_nfc + 1, (1 << g_cw) - 1)};
         else
            forced_codes = '{lzwd_pkg::CLEAR_CODE, lzwd_pkg::FIRST_FREE};
         guard = 0;
         while (sst != lzwd_pkg::ST_ERROR && guard < 300) begin
            next_item();
            guard++;
         end
         repeat (5) next_item();
      end else begin
         write_limit(emitted + $urandom_range(0, 3));
         repeat (20) next_item();
      end

      write_limit(32'h0);
      repeat (5) next_item();
      write_limit($urandom);
      repeat (5) next_item();

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
